FILE: hw/rtl/mlp_relu_two_hidden_inference_unit_defines.svh
// assertion macros for the perceptron inference unit
// no dependencies; taken in by the files that assert
`ifndef MLP_RELU_TWO_HIDDEN_INFERENCE_UNIT_DEFINES_SVH
`define MLP_RELU_TWO_HIDDEN_INFERENCE_UNIT_DEFINES_SVH

// checked on every edge outside reset
`define MRTHI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define MRTHI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/mrthi_pkg.sv
// shared types, codes and defaults of the perceptron inference unit
// no dependencies
`default_nettype none

package mrthi_pkg;

   localparam int HIDDEN_ONE_DEF  = 1000;
   localparam int HIDDEN_TWO_DEF  = 500;
   localparam int WEIGHT_BITS_DEF = 16;
   localparam int ACT_BITS_DEF    = 32;

   localparam int W_FRAC  = 12;
   localparam int ACT_ONE = 65536;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   localparam logic [1:0] LAYER_ONE = 2'd0;
   localparam logic [1:0] LAYER_TWO = 2'd1;
   localparam logic [1:0] LAYER_OUT = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } mac_ctl_type;

   typedef struct packed {
      logic vld;
      logic sat;
   } mac_res_type;

   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mrthi_if.sv
// request and response channel interfaces of the perceptron inference unit
// depends on mrthi_pkg
`default_nettype none

interface mrthi_req_if import mrthi_pkg::*; #(
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [1:0]                    layer;
   logic [9:0]                    row;
   logic [9:0]                    col;
   logic signed [WEIGHT_BITS-1:0] weight;
   logic signed [31:0]            sample_in;

   modport source (output valid, func, layer, row, col, weight, sample_in, input ready);
   modport sink   (input valid, func, layer, row, col, weight, sample_in, output ready);
endinterface

interface mrthi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] net_out;
   logic               saturated;

   modport source (output valid, net_out, saturated, input ready);
   modport sink   (input valid, net_out, saturated, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mrthi_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module mrthi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mrthi_mac.sv
// shared multiply-accumulate unit with rescale and saturation
// depends on mrthi_pkg
`default_nettype none

module mrthi_mac import mrthi_pkg::*; #(
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
   parameter int OPND_W      = 32,
   parameter int ACT_BITS    = ACT_BITS_DEF,
   parameter int TERMS       = HIDDEN_ONE_DEF + 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mac_ctl_type                   ctl,
   input  wire logic signed [WEIGHT_BITS-1:0] weight,
   input  wire logic signed [OPND_W-1:0]      opnd,
   output mac_res_type                        res,
   output logic signed [ACT_BITS-1:0]         value
);

   localparam int PW    = WEIGHT_BITS + OPND_W;
   localparam int ACC_W = PW + $clog2(TERMS + 1);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (ACT_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (W_FRAC - 1);

   mac_ctl_type             p2_ctl_ff;
   logic signed [PW-1:0]    prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic                    fin_ff;
   logic signed [ACC_W-1:0] scaled;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_ctl_ff <= '0;
         fin_ff    <= 1'b0;
      end else begin
         p2_ctl_ff <= ctl;
         fin_ff    <= p2_ctl_ff.vld && p2_ctl_ff.last;
      end
      prod_ff <= PW'(weight) * PW'(opnd);
      if (p2_ctl_ff.vld) begin
         acc_ff <= p2_ctl_ff.first ? ACC_W'(prod_ff) : ACC_W'(acc_ff + ACC_W'(prod_ff));
      end
   end

   // round half up, drop the weight fraction
   always_comb begin
      scaled    = (acc_ff + RND) >>> W_FRAC;
      res.vld   = fin_ff;
      res.sat   = 1'b0;
      priority if (scaled > SAT_HI) begin
         value   = ACT_BITS'(SAT_HI);
         res.sat = fin_ff;
      end else if (scaled < SAT_LO) begin
         value   = ACT_BITS'(SAT_LO);
         res.sat = fin_ff;
      end else begin
         value   = ACT_BITS'(scaled);
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mlp_relu_two_hidden_inference_unit.sv
// Perceptron inference unit, 1 - HIDDEN_ONE - HIDDEN_TWO - 1, ReLU after both hidden layers.
// A load transfer (func 0) writes one weight; loads to an unused layer or out of
// shape are dropped. An evaluate transfer (func 1) runs every neuron on one shared
// multiply-accumulate unit fed by one read a cycle from the weight and activation memories
// while a neuron's terms are issued, and only when the evaluation is through is the next
// transfer taken. The result waits in an output register; weights must all be loaded
// before the first evaluation.
// depends on mrthi_pkg, mrthi_if, mrthi_ram, mrthi_mac and the defines header
`default_nettype none
`include "mlp_relu_two_hidden_inference_unit_defines.svh"

module mlp_relu_two_hidden_inference_unit import mrthi_pkg::*; #(
   parameter int HIDDEN_ONE  = HIDDEN_ONE_DEF,
   parameter int HIDDEN_TWO  = HIDDEN_TWO_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
   parameter int ACT_BITS    = ACT_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mrthi_req_if.sink   req_ch,
   mrthi_rsp_if.source rsp_ch
);

   localparam int W1_DEPTH = 2 * HIDDEN_ONE;
   localparam int W2_DEPTH = HIDDEN_TWO * (HIDDEN_ONE + 1);
   localparam int W3_DEPTH = HIDDEN_TWO + 1;
   localparam int W1_AW    = addr_bits(W1_DEPTH);
   localparam int W2_AW    = addr_bits(W2_DEPTH);
   localparam int W3_AW    = addr_bits(W3_DEPTH);
   localparam int H1_AW    = addr_bits(HIDDEN_ONE);
   localparam int H2_AW    = addr_bits(HIDDEN_TWO);
   localparam int WC_AW    = (W1_AW > W2_AW) ? ((W1_AW > W3_AW) ? W1_AW : W3_AW)
                                             : ((W2_AW > W3_AW) ? W2_AW : W3_AW);
   localparam int MAX_N    = (HIDDEN_ONE > HIDDEN_TWO) ? HIDDEN_ONE : HIDDEN_TWO;
   localparam int CNT_W    = $clog2(MAX_N + 1);
   localparam int OPND_W   = (ACT_BITS > 32) ? ACT_BITS : 32;

   state_type                    state_ff, state_in;
   logic [1:0]                   layer_ff, layer_in;
   logic [CNT_W-1:0]             i_ff, i_in;
   logic [CNT_W-1:0]             k_ff, k_in;
   logic [WC_AW-1:0]             wc_ff, wc_in;
   logic signed [31:0]           x_ff, x_in;
   logic                         sat_ff, sat_in;
   logic signed [ACT_BITS-1:0]   y_ff, y_in;
   logic                         rsp_vld_ff, rsp_vld_in;
   logic signed [31:0]           rsp_out_ff, rsp_out_in;
   logic                         rsp_sat_ff, rsp_sat_in;

   mac_ctl_type                  issue_ctl, p1_ctl_ff;
   logic                         p1_bias_ff;
   logic [1:0]                   p1_layer_ff;

   logic                         req_fire, ld_fire;
   logic                         w1_we, w2_we, w3_we;
   logic [W1_AW-1:0]             w1_wa;
   logic [W2_AW-1:0]             w2_wa;
   logic [W3_AW-1:0]             w3_wa;
   logic [WEIGHT_BITS-1:0]       w1_rd, w2_rd, w3_rd;
   logic [ACT_BITS-1:0]          h1_rd, h2_rd;
   logic                         h1_we, h2_we;
   logic [CNT_W-1:0]             act_ra;
   logic [CNT_W-1:0]             n_cur, last_neuron;
   logic signed [WEIGHT_BITS-1:0] mac_w;
   logic signed [OPND_W-1:0]     mac_opnd;
   mac_res_type                  mac_res;
   logic signed [ACT_BITS-1:0]   mac_value;
   logic [ACT_BITS-1:0]          relu_value;
   logic signed [63:0]           y_wide;

   // load decode
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign ld_fire      = req_fire && (req_ch.func == FUNC_LOAD);
   assign w1_we = ld_fire && (req_ch.layer == LAYER_ONE) && (req_ch.row < HIDDEN_ONE)
                  && (req_ch.col < 2);
   assign w2_we = ld_fire && (req_ch.layer == LAYER_TWO) && (req_ch.row < HIDDEN_TWO)
                  && (req_ch.col < HIDDEN_ONE + 1);
   assign w3_we = ld_fire && (req_ch.layer == LAYER_OUT) && (req_ch.row == 10'd0)
                  && (req_ch.col < HIDDEN_TWO + 1);
   assign w1_wa = W1_AW'((32'(req_ch.row) << 1) + 32'(req_ch.col));
   assign w2_wa = W2_AW'(32'(req_ch.row) * 32'(HIDDEN_ONE + 1) + 32'(req_ch.col));
   assign w3_wa = W3_AW'(req_ch.col);

   assign act_ra     = CNT_W'(k_ff - 1'b1);
   assign relu_value = mac_value[ACT_BITS-1] ? '0 : mac_value;
   assign h1_we      = mac_res.vld && (layer_ff == LAYER_ONE);
   assign h2_we      = mac_res.vld && (layer_ff == LAYER_TWO);

   mrthi_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(W1_DEPTH)) u_w1 (
      .clock(clock), .we(w1_we), .waddr(w1_wa), .wdata(req_ch.weight),
      .raddr(wc_ff[W1_AW-1:0]), .rdata(w1_rd));
   mrthi_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(W2_DEPTH)) u_w2 (
      .clock(clock), .we(w2_we), .waddr(w2_wa), .wdata(req_ch.weight),
      .raddr(wc_ff[W2_AW-1:0]), .rdata(w2_rd));
   mrthi_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(W3_DEPTH)) u_w3 (
      .clock(clock), .we(w3_we), .waddr(w3_wa), .wdata(req_ch.weight),
      .raddr(wc_ff[W3_AW-1:0]), .rdata(w3_rd));
   mrthi_ram #(.WIDTH(ACT_BITS), .DEPTH(HIDDEN_ONE)) u_h1 (
      .clock(clock), .we(h1_we), .waddr(i_ff[H1_AW-1:0]), .wdata(relu_value),
      .raddr(act_ra[H1_AW-1:0]), .rdata(h1_rd));
   mrthi_ram #(.WIDTH(ACT_BITS), .DEPTH(HIDDEN_TWO)) u_h2 (
      .clock(clock), .we(h2_we), .waddr(i_ff[H2_AW-1:0]), .wdata(relu_value),
      .raddr(act_ra[H2_AW-1:0]), .rdata(h2_rd));

   // operand select once read data is back
   always_comb begin
      unique case (p1_layer_ff)
         LAYER_ONE: mac_w = $signed(w1_rd);
         LAYER_TWO: mac_w = $signed(w2_rd);
         default:   mac_w = $signed(w3_rd);
      endcase
      priority if (p1_bias_ff) begin
         mac_opnd = OPND_W'(ACT_ONE);
      end else if (p1_layer_ff == LAYER_ONE) begin
         mac_opnd = OPND_W'(x_ff);
      end else if (p1_layer_ff == LAYER_TWO) begin
         mac_opnd = OPND_W'($signed(h1_rd));
      end else begin
         mac_opnd = OPND_W'($signed(h2_rd));
      end
   end

   mrthi_mac #(
      .WEIGHT_BITS(WEIGHT_BITS), .OPND_W(OPND_W), .ACT_BITS(ACT_BITS), .TERMS(MAX_N + 1)
   ) u_mac (
      .clock(clock), .reset(reset), .ctl(p1_ctl_ff), .weight(mac_w), .opnd(mac_opnd),
      .res(mac_res), .value(mac_value));

   // sequencer
   always_comb begin
      state_in   = state_ff;
      layer_in   = layer_ff;
      i_in       = i_ff;
      k_in       = k_ff;
      wc_in      = wc_ff;
      x_in       = x_ff;
      sat_in     = sat_ff;
      y_in       = y_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ch.ready;
      rsp_out_in = rsp_out_ff;
      rsp_sat_in = rsp_sat_ff;
      issue_ctl  = '0;
      unique case (layer_ff)
         LAYER_ONE: begin
            n_cur       = CNT_W'(1);
            last_neuron = CNT_W'(HIDDEN_ONE - 1);
         end
         LAYER_TWO: begin
            n_cur       = CNT_W'(HIDDEN_ONE);
            last_neuron = CNT_W'(HIDDEN_TWO - 1);
         end
         default: begin
            n_cur       = CNT_W'(HIDDEN_TWO);
            last_neuron = '0;
         end
      endcase
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_ch.func == FUNC_EVAL)) begin
               x_in     = req_ch.sample_in;
               layer_in = LAYER_ONE;
               i_in     = '0;
               k_in     = '0;
               wc_in    = '0;
               sat_in   = 1'b0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            issue_ctl.vld   = 1'b1;
            issue_ctl.first = (k_ff == '0);
            issue_ctl.last  = (k_ff == n_cur);
            wc_in           = WC_AW'(wc_ff + 1'b1);
            if (k_ff == n_cur) begin
               k_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in     = CNT_W'(k_ff + 1'b1);
            end
         end
         ST_DRAIN: begin
            if (mac_res.vld) begin
               sat_in = sat_ff || mac_res.sat;
               if (i_ff == last_neuron) begin
                  i_in  = '0;
                  wc_in = '0;
                  unique case (layer_ff)
                     LAYER_ONE: begin
                        layer_in = LAYER_TWO;
                        state_in = ST_ISSUE;
                     end
                     LAYER_TWO: begin
                        layer_in = LAYER_OUT;
                        state_in = ST_ISSUE;
                     end
                     default: begin
                        y_in     = mac_value;
                        state_in = ST_OUTPUT;
                     end
                  endcase
               end else begin
                  i_in     = CNT_W'(i_ff + 1'b1);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_OUTPUT: begin
            if (!rsp_vld_ff || rsp_ch.ready) begin
               rsp_vld_in = 1'b1;
               rsp_out_in = y_wide[31:0];
               rsp_sat_in = sat_ff;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign y_wide = 64'(y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         p1_ctl_ff  <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         p1_ctl_ff  <= issue_ctl;
         rsp_vld_ff <= rsp_vld_in;
      end
      layer_ff    <= layer_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      wc_ff       <= wc_in;
      x_ff        <= x_in;
      sat_ff      <= sat_in;
      y_ff        <= y_in;
      rsp_out_ff  <= rsp_out_in;
      rsp_sat_ff  <= rsp_sat_in;
      p1_bias_ff  <= issue_ctl.first;
      p1_layer_ff <= layer_ff;
   end

   assign rsp_ch.valid     = rsp_vld_ff;
   assign rsp_ch.net_out   = rsp_out_ff;
   assign rsp_ch.saturated = rsp_sat_ff;

   `MRTHI_ASSERT(a_fin_in_drain, clock, reset, mac_res.vld |-> (state_ff == ST_DRAIN),
      "neuron finished outside drain")
   `MRTHI_ASSERT(a_idle_empty, clock, reset,
      (state_ff == ST_IDLE) |-> (!p1_ctl_ff.vld && !mac_res.vld), "pipeline busy while idle")
   `MRTHI_ASSERT(a_rsp_from_output, clock, reset,
      $rose(rsp_vld_ff) |-> ($past(state_ff) == ST_OUTPUT), "result raised outside output")

endmodule

`default_nettype wire
